// ===== rtl/cslp_pkg.sv =====
// ----------------------------------------------------------------------------
// cslp_pkg
// Shared types and constants of the call stack latency profiler.
// ----------------------------------------------------------------------------
`default_nettype none

package cslp_pkg;

  localparam int STACK_DEPTH = 64;

  localparam int DATA_W  = 64;
  localparam int TIME_W  = 27;
  localparam int DEPTH_W = 6;
  localparam int MAXD_W  = 7;

  localparam logic [TIME_W-1:0] TIME_MAX  = TIME_W'(99999999);
  localparam logic [TIME_W:0]   TIME_WRAP = (TIME_W+1)'(100000000);

  localparam int CFG_AW = 4;
  localparam int CFG_DW = 32;

  localparam logic [1:0] REG_RECORD_ENABLE = 2'd0;
  localparam logic [1:0] REG_TIMED_THREAD  = 2'd1;
  localparam logic [1:0] REG_MIN_COST_US   = 2'd2;
  localparam logic [1:0] REG_MAX_DEPTH     = 2'd3;

  localparam logic OP_CALL   = 1'b0;
  localparam logic OP_RETURN = 1'b1;

  typedef struct packed {
    logic [DATA_W-1:0] class_id;
    logic [DATA_W-1:0] selector_id;
    logic [DATA_W-1:0] return_addr;
    logic [TIME_W-1:0] stamp;
  } entry_t;

  typedef struct packed {
    logic [DATA_W-1:0]  ret_addr;
    logic               logged;
    logic [DEPTH_W-1:0] depth;
    logic [TIME_W-1:0]  cost_us;
    logic [DATA_W-1:0]  rec_class;
    logic [DATA_W-1:0]  rec_selector;
    logic               caller_valid;
    logic [DATA_W-1:0]  caller_class;
    logic [DATA_W-1:0]  caller_selector;
    logic [DATA_W-1:0]  caller_ret_addr;
    logic               stack_error;
  } result_t;

endpackage

`default_nettype wire

// ===== rtl/cslp_ifs.sv =====
// ----------------------------------------------------------------------------
// cslp channel interfaces
// Valid/ready request channels for call/return events and profiler results.
// ----------------------------------------------------------------------------
`default_nettype none

interface cslp_in_if;
  logic                          valid;
  logic                          ready;
  logic                          opcode;
  logic [cslp_pkg::DATA_W-1:0]   class_id;
  logic [cslp_pkg::DATA_W-1:0]   selector_id;
  logic [cslp_pkg::DATA_W-1:0]   return_addr;
  logic [cslp_pkg::TIME_W-1:0]   time_us;

  modport source (output valid, opcode, class_id, selector_id, return_addr, time_us,
                  input ready);
  modport sink   (input valid, opcode, class_id, selector_id, return_addr, time_us,
                  output ready);
endinterface

interface cslp_out_if;
  logic                          valid;
  logic                          ready;
  logic [cslp_pkg::DATA_W-1:0]   ret_addr;
  logic                          logged;
  logic [cslp_pkg::DEPTH_W-1:0]  depth;
  logic [cslp_pkg::TIME_W-1:0]   cost_us;
  logic [cslp_pkg::DATA_W-1:0]   rec_class;
  logic [cslp_pkg::DATA_W-1:0]   rec_selector;
  logic                          caller_valid;
  logic [cslp_pkg::DATA_W-1:0]   caller_class;
  logic [cslp_pkg::DATA_W-1:0]   caller_selector;
  logic [cslp_pkg::DATA_W-1:0]   caller_ret_addr;
  logic                          stack_error;

  modport source (output valid, ret_addr, logged, depth, cost_us, rec_class, rec_selector,
                         caller_valid, caller_class, caller_selector, caller_ret_addr,
                         stack_error,
                  input ready);
  modport sink   (input valid, ret_addr, logged, depth, cost_us, rec_class, rec_selector,
                        caller_valid, caller_class, caller_selector, caller_ret_addr,
                        stack_error,
                  output ready);
endinterface

`default_nettype wire

// ===== rtl/call_stack_latency_profiler_core.sv =====
// ----------------------------------------------------------------------------
// call_stack_latency_profiler_core
// Shadow call stack in a two-read-port memory with per-call timing and logging.
// Calls: one request per cycle while in_ch.ready is high, no result unless the stack overflows.
// Returns: the stack entries are read into top_rd_r/below_rd_r, then the result is registered
//   once the output slot is free; no new request is taken until that result is loaded.
// Reset clears stack count, overflow flag, state and output valid and loads config defaults; memory is not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module call_stack_latency_profiler_core #(
  parameter int STACK_DEPTH = cslp_pkg::STACK_DEPTH
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  cslp_in_if.sink                          in_ch,
  cslp_out_if.source                       out_ch,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [cslp_pkg::CFG_AW-1:0] paddr,
  input  wire logic [cslp_pkg::CFG_DW-1:0] pwdata,
  output logic      [cslp_pkg::CFG_DW-1:0] prdata,
  output logic                             pready
);

  localparam int AW   = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int CW   = $clog2(STACK_DEPTH + 1);
  localparam int CMPW = (CW > cslp_pkg::MAXD_W) ? CW : cslp_pkg::MAXD_W;
  localparam int DW   = cslp_pkg::DEPTH_W;
  localparam int TW   = cslp_pkg::TIME_W;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_POP  = 2'd1;
  localparam logic [1:0] ST_ERR  = 2'd2;

  // configuration
  logic                          record_enable_r;
  logic                          timed_thread_r;
  logic [TW-1:0]                 min_cost_us_r;
  logic [cslp_pkg::MAXD_W-1:0]   max_depth_r;
  logic                          cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      record_enable_r <= 1'b1;
      timed_thread_r  <= 1'b1;
      min_cost_us_r   <= TW'(1000);
      max_depth_r     <= cslp_pkg::MAXD_W'(3);
    end else if (cfg_wr) begin
      case (paddr[3:2])
        cslp_pkg::REG_RECORD_ENABLE: record_enable_r <= pwdata[0];
        cslp_pkg::REG_TIMED_THREAD:  timed_thread_r  <= pwdata[0];
        cslp_pkg::REG_MIN_COST_US:   min_cost_us_r   <= pwdata[TW-1:0];
        cslp_pkg::REG_MAX_DEPTH:     max_depth_r     <= pwdata[cslp_pkg::MAXD_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      cslp_pkg::REG_RECORD_ENABLE: prdata = cslp_pkg::CFG_DW'(record_enable_r);
      cslp_pkg::REG_TIMED_THREAD:  prdata = cslp_pkg::CFG_DW'(timed_thread_r);
      cslp_pkg::REG_MIN_COST_US:   prdata = cslp_pkg::CFG_DW'(min_cost_us_r);
      cslp_pkg::REG_MAX_DEPTH:     prdata = cslp_pkg::CFG_DW'(max_depth_r);
      default:                     prdata = '0;
    endcase
  end

  // control
  logic [1:0]        state_r, state_nxt;
  logic [CW-1:0]     count_r, count_nxt;
  logic              overflow_r, overflow_nxt;
  logic [CW-1:0]     pop_depth_r;
  logic [TW-1:0]     now_r;
  logic              in_acc, is_push, is_pop, stack_full, stack_empty;
  logic              push_ok, pop_ok, slot_free, load_out;
  logic [TW-1:0]     now_sat;

  assign in_ch.ready = (state_r == ST_IDLE);
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign is_push     = in_acc && (in_ch.opcode == cslp_pkg::OP_CALL);
  assign is_pop      = in_acc && (in_ch.opcode == cslp_pkg::OP_RETURN);
  assign stack_full  = (count_r == CW'(STACK_DEPTH));
  assign stack_empty = (count_r == '0);
  assign push_ok     = is_push && !stack_full;
  assign pop_ok      = is_pop && !stack_empty;
  assign now_sat     = (in_ch.time_us > cslp_pkg::TIME_MAX) ? cslp_pkg::TIME_MAX
                                                            : in_ch.time_us;
  assign slot_free   = !out_ch.valid || out_ch.ready;
  assign load_out    = slot_free && ((state_r == ST_POP) || (state_r == ST_ERR));

  always_comb begin
    state_nxt    = state_r;
    count_nxt    = count_r;
    overflow_nxt = overflow_r;
    case (state_r)
      ST_IDLE: begin
        if (push_ok) begin
          count_nxt = count_r + CW'(1);
        end else if (is_push) begin
          overflow_nxt = 1'b1;
          state_nxt    = ST_ERR;
        end else if (pop_ok) begin
          count_nxt = count_r - CW'(1);
          state_nxt = ST_POP;
        end else if (is_pop) begin
          state_nxt = ST_ERR;
        end
      end
      ST_POP, ST_ERR: begin
        if (slot_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      count_r    <= '0;
      overflow_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      count_r    <= count_nxt;
      overflow_r <= overflow_nxt;
    end
  end

  // stack memory, one write port and two read ports
  cslp_pkg::entry_t mem_r [STACK_DEPTH];
  cslp_pkg::entry_t top_rd_r, below_rd_r;
  logic [CW-1:0]    top_idx, below_idx;

  assign top_idx   = count_r - CW'(1);
  assign below_idx = count_r - CW'(2);

  always_ff @(posedge clk) begin
    if (push_ok) begin
      mem_r[count_r[AW-1:0]] <= '{class_id:    in_ch.class_id,
                                  selector_id: in_ch.selector_id,
                                  return_addr: in_ch.return_addr,
                                  stamp:       now_sat};
    end
    if (pop_ok) begin
      top_rd_r    <= mem_r[top_idx[AW-1:0]];
      below_rd_r  <= mem_r[below_idx[AW-1:0]];
      pop_depth_r <= top_idx;
      now_r       <= now_sat;
    end
  end

  // cost and logging
  logic [TW-1:0]      stamp_sat;
  logic [TW:0]        t_ext;
  logic [TW:0]        cost_ext;
  logic [TW-1:0]      cost;
  logic               timing_on, has_caller, do_log;
  cslp_pkg::result_t  pop_res, res_r, res_nxt;
  logic               out_valid_r;

  assign timing_on  = record_enable_r && timed_thread_r;
  assign stamp_sat  = (top_rd_r.stamp > cslp_pkg::TIME_MAX) ? cslp_pkg::TIME_MAX
                                                            : top_rd_r.stamp;
  assign t_ext      = (now_r < stamp_sat) ? ((TW+1)'(now_r) + cslp_pkg::TIME_WRAP)
                                          : (TW+1)'(now_r);
  assign cost_ext   = t_ext - (TW+1)'(stamp_sat);
  assign cost       = cost_ext[TW-1:0];
  assign has_caller = (pop_depth_r != '0);
  assign do_log     = timing_on && (cost > min_cost_us_r)
                      && (CMPW'(pop_depth_r) <= CMPW'(max_depth_r));

  always_comb begin
    pop_res                 = '0;
    pop_res.ret_addr        = top_rd_r.return_addr;
    pop_res.logged          = do_log;
    pop_res.depth           = DW'(pop_depth_r);
    pop_res.cost_us         = timing_on ? cost : '0;
    pop_res.rec_class       = top_rd_r.class_id;
    pop_res.rec_selector    = top_rd_r.selector_id;
    pop_res.caller_valid    = has_caller;
    pop_res.caller_class    = has_caller ? below_rd_r.class_id : '0;
    pop_res.caller_selector = has_caller ? below_rd_r.selector_id : '0;
    pop_res.caller_ret_addr = has_caller ? below_rd_r.return_addr : '0;
    pop_res.stack_error     = overflow_r;
  end

  always_comb begin
    if (state_r == ST_POP) begin
      res_nxt = pop_res;
    end else begin
      res_nxt             = '0;
      res_nxt.stack_error = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      res_r <= res_nxt;
    end
  end

  assign out_ch.valid           = out_valid_r;
  assign out_ch.ret_addr        = res_r.ret_addr;
  assign out_ch.logged          = res_r.logged;
  assign out_ch.depth           = res_r.depth;
  assign out_ch.cost_us         = res_r.cost_us;
  assign out_ch.rec_class       = res_r.rec_class;
  assign out_ch.rec_selector    = res_r.rec_selector;
  assign out_ch.caller_valid    = res_r.caller_valid;
  assign out_ch.caller_class    = res_r.caller_class;
  assign out_ch.caller_selector = res_r.caller_selector;
  assign out_ch.caller_ret_addr = res_r.caller_ret_addr;
  assign out_ch.stack_error     = res_r.stack_error;

endmodule

`default_nettype wire
